@@ sv/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define NFBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked check that also holds during reset.
`define NFBA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/nfba_pkg.sv @@
// Shared types and constants of the next-fit bitmap allocator.
package nfba_pkg;

	localparam int NBLOCKS_DEF = 4096;
	localparam int LANES       = 8;
	localparam int SIZE_W      = 16;
	localparam int OFF_W       = 16;
	localparam int CNT_W       = 13;
	localparam int NB_W        = 14;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_ASET,
		ST_MRD,
		ST_MWR,
		ST_FRD,
		ST_FCHK,
		ST_CHECK,
		ST_CRD,
		ST_CWR,
		ST_DONE
	} state_t;

endpackage

@@ sv/nfba_ram.sv @@
// Generic single-port synchronous RAM with registered read.
module nfba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/next_fit_bitmap_block_allocator_core.sv @@
// Next-fit bitmap block allocator: top level with scan, mark and release sequencer.
//
//  channel  dir  payload                                      handshake
//  s_*      in   tuser: command; tdata: size, byte offset     s_tvalid / s_tready
//  m_*      out  tuser: ok; tdata: offset, used, live counts  m_tvalid / m_tready
//
// One command at a time. The used map is held as words of 8 blocks in one RAM.
// Allocate: scan W words from the pointer (W up to about 2*NBLOCKS/8 with the wrap),
// then write the header and read and write back each word marked.
// Free: read the header, check W data words, then read and write back each word cleared;
// a command settled at acceptance goes straight to its result. After reset a clearing
// pass over all NBLOCKS/8 map words runs before s_tready rises. A result waiting on
// m_tready holds the sequencer in its last step but never blocks acceptance in idle.
`include "assert_macros.svh"

module next_fit_bitmap_block_allocator_core #(
	parameter int NBLOCKS = nfba_pkg::NBLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [15:0] size_bytes, [31:16] byte_offset
	input  logic [0:0]  s_tuser,  // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // [15:0] result_offset, [28:16] used_blocks,
	                              // [41:29] live_count, rest zero
	output logic [0:0]  m_tuser   // [0] ok
);

	localparam int PW  = $clog2(NBLOCKS + 1);
	localparam int AW  = PW - 3;
	localparam int IAW = AW + 1;
	localparam int NW  = (NBLOCKS + 7) / 8;
	localparam int RAW = $clog2(NW);
	localparam int HAW = $clog2(NBLOCKS);
	localparam int RW  = PW + 1;
	localparam int CW  = ((PW > nfba_pkg::NB_W) ? PW : nfba_pkg::NB_W) + 1;
	localparam int unsigned END_OFF = 8 * NBLOCKS;
	localparam int L   = nfba_pkg::LANES;

	nfba_pkg::state_t state_q, state_d;

	logic [IAW-1:0] ia_q;
	logic [AW-1:0]  last_q;
	logic [PW-1:0]  lo_q, hi_q, fpos_q;
	logic           v_s1;
	logic [AW-1:0]  wa_s1;
	logic [RW-1:0]  run_q;
	logic [nfba_pkg::NB_W-1:0]   n_q;
	logic [nfba_pkg::SIZE_W-1:0] size_q;
	logic [HAW-1:0] hdr_q, start_q;
	logic           seg2_q;
	logic [nfba_pkg::CNT_W-1:0]  used_q, live_q;
	logic           res_ok_q;
	logic [nfba_pkg::OFF_W-1:0]  res_off_q;
	logic           m_valid_q, m_ok_q;
	logic [nfba_pkg::OFF_W-1:0]  m_off_q;
	logic [nfba_pkg::CNT_W-1:0]  m_used_q, m_live_q;

	// RAM ports
	logic           bm_we, hs_we;
	logic [RAW-1:0] bm_addr;
	logic [HAW-1:0] hs_addr;
	logic [L-1:0]   bm_wdata, bm_rdata;
	logic [nfba_pkg::SIZE_W-1:0] hs_rdata;

	nfba_ram #(.WIDTH(L), .DEPTH(NW)) u_map (
		.clk(clk), .we(bm_we), .addr(bm_addr), .wdata(bm_wdata), .rdata(bm_rdata)
	);

	nfba_ram #(.WIDTH(nfba_pkg::SIZE_W), .DEPTH(NBLOCKS)) u_hdr (
		.clk(clk), .we(hs_we), .addr(hs_addr), .wdata(size_q), .rdata(hs_rdata)
	);

	// Input decode
	logic                        s_acc, in_cmd;
	logic [nfba_pkg::SIZE_W-1:0] in_size;
	logic [nfba_pkg::OFF_W-1:0]  in_off;
	logic [16:0]                 size_sum;
	logic [nfba_pkg::NB_W-1:0]   n_in;
	logic [12:0]                 hdr_in;
	logic                        alloc_early, free_early;

	assign s_tready = (state_q == nfba_pkg::ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign in_cmd   = s_tuser[0];
	assign in_size  = s_tdata[15:0];
	assign in_off   = s_tdata[31:16];
	assign size_sum = {1'b0, in_size} + 17'd7;
	assign n_in     = size_sum[16:3];
	assign hdr_in   = in_off[15:3] - 13'd1;
	assign alloc_early = (in_size == '0) || (32'(n_in) + 32'd1 > 32'(NBLOCKS));
	assign free_early  = (32'(in_off) == END_OFF) || (in_off < 16'd8)
		|| (32'(hdr_in) >= 32'(NBLOCKS));

	// Word under test; words past the RAM read as free
	logic [L-1:0]  dword;
	logic [CW-1:0] need;
	logic [RW-1:0] run_n;
	logic          hit, bad;
	logic [PW-1:0] hit_pos, lpos, mpos;
	logic [L-1:0]  mask;

	assign dword = ({1'b0, wa_s1} >= IAW'(NW)) ? '0 : bm_rdata;
	assign need  = CW'(n_q) + CW'(2);

	always_comb begin
		run_n   = run_q;
		hit     = 1'b0;
		hit_pos = '0;
		bad     = 1'b0;
		lpos    = '0;
		for (int j = 0; j < L; j++) begin
			lpos = {wa_s1, 3'(j)};
			if (lpos >= lo_q && lpos <= hi_q) begin
				if (!dword[j]) begin
					bad = 1'b1;
				end
				if (!hit) begin
					if (dword[j]) begin
						run_n = '0;
					end else begin
						run_n = run_n + RW'(1);
					end
					if (CW'(run_n) == need) begin
						hit     = 1'b1;
						hit_pos = lpos;
					end
				end
			end
		end
	end

	always_comb begin
		mask = '0;
		mpos = '0;
		for (int j = 0; j < L; j++) begin
			mpos = {ia_q[AW-1:0], 3'(j)};
			mask[j] = (mpos >= lo_q) && (mpos <= hi_q);
		end
	end

	// Sequencer helpers
	logic          seg_end, ia_last, can_issue, out_free;
	logic [CW-1:0] hi2_sum;
	logic [PW-1:0] hi2, st_pos, c1, fm1, h1, hn;
	logic [nfba_pkg::NB_W-1:0] nf;
	logic [16:0]   hs_sum;
	logic          hbit, nofit;

	assign seg_end   = (wa_s1 == last_q);
	assign ia_last   = (ia_q[AW-1:0] == last_q);
	assign can_issue = (ia_q <= {1'b0, last_q});
	assign out_free  = !m_valid_q || m_tready;
	assign hi2_sum   = CW'(start_q) + CW'(n_q);
	assign hi2       = (hi2_sum > CW'(NBLOCKS)) ? PW'(NBLOCKS) : PW'(hi2_sum);
	assign st_pos    = PW'(start_q);
	assign c1        = fpos_q - PW'(n_q);
	assign fm1       = fpos_q - PW'(1);
	assign hs_sum    = {1'b0, hs_rdata} + 17'd7;
	assign nf        = hs_sum[16:3];
	assign hbit      = bm_rdata[hdr_q[2:0]];
	assign nofit     = (32'(hdr_q) + 32'(nf) + 32'd1) > 32'(NBLOCKS);
	assign h1        = PW'(hdr_q) + PW'(1);
	assign hn        = PW'(32'(hdr_q) + 32'(nf));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nfba_pkg::ST_CLEAR: if (ia_q == IAW'(NW - 1)) state_d = nfba_pkg::ST_IDLE;
			nfba_pkg::ST_IDLE: begin
				if (s_acc) begin
					if (in_cmd == nfba_pkg::CMD_FREE) begin
						state_d = free_early ? nfba_pkg::ST_DONE : nfba_pkg::ST_FRD;
					end else begin
						state_d = alloc_early ? nfba_pkg::ST_DONE : nfba_pkg::ST_SCAN;
					end
				end
			end
			nfba_pkg::ST_SCAN: begin
				if (v_s1) begin
					if (hit) begin
						state_d = nfba_pkg::ST_ASET;
					end else if (seg_end && !seg2_q) begin
						state_d = nfba_pkg::ST_DONE;
					end
				end
			end
			nfba_pkg::ST_ASET: state_d = nfba_pkg::ST_MRD;
			nfba_pkg::ST_MRD:  state_d = nfba_pkg::ST_MWR;
			nfba_pkg::ST_MWR:  state_d = ia_last ? nfba_pkg::ST_DONE : nfba_pkg::ST_MRD;
			nfba_pkg::ST_FRD:  state_d = nfba_pkg::ST_FCHK;
			nfba_pkg::ST_FCHK: begin
				state_d = (hbit || nofit || nf == '0) ? nfba_pkg::ST_DONE
					: nfba_pkg::ST_CHECK;
			end
			nfba_pkg::ST_CHECK: begin
				if (v_s1) begin
					if (bad) begin
						state_d = nfba_pkg::ST_DONE;
					end else if (seg_end) begin
						state_d = nfba_pkg::ST_CRD;
					end
				end
			end
			nfba_pkg::ST_CRD:  state_d = nfba_pkg::ST_CWR;
			nfba_pkg::ST_CWR:  state_d = ia_last ? nfba_pkg::ST_DONE : nfba_pkg::ST_CRD;
			nfba_pkg::ST_DONE: if (out_free) state_d = nfba_pkg::ST_IDLE;
			default:           state_d = nfba_pkg::ST_IDLE;
		endcase
	end

	// RAM controls
	always_comb begin
		bm_we    = 1'b0;
		bm_addr  = ia_q[RAW-1:0];
		bm_wdata = '0;
		hs_we    = 1'b0;
		hs_addr  = '0;
		unique case (state_q)
			nfba_pkg::ST_CLEAR: bm_we = 1'b1;
			nfba_pkg::ST_MWR: begin
				bm_we    = 1'b1;
				bm_wdata = bm_rdata | mask;
			end
			nfba_pkg::ST_CWR: begin
				bm_we    = 1'b1;
				bm_wdata = bm_rdata & ~mask;
			end
			nfba_pkg::ST_ASET: begin
				hs_we   = 1'b1;
				hs_addr = HAW'(c1 - PW'(1));
			end
			nfba_pkg::ST_FRD: begin
				bm_addr = RAW'(hdr_q >> 3);
				hs_addr = hdr_q;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= nfba_pkg::ST_CLEAR;
			ia_q      <= '0;
			v_s1      <= 1'b0;
			wa_s1     <= '0;
			seg2_q    <= 1'b0;
			start_q   <= '0;
			used_q    <= '0;
			live_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == nfba_pkg::ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				nfba_pkg::ST_CLEAR: ia_q <= ia_q + IAW'(1);
				nfba_pkg::ST_IDLE: begin
					ia_q   <= IAW'(st_pos[PW-1:3]);
					v_s1   <= 1'b0;
					seg2_q <= (start_q != '0);
				end
				nfba_pkg::ST_SCAN, nfba_pkg::ST_CHECK: begin
					wa_s1 <= ia_q[AW-1:0];
					if (state_q == nfba_pkg::ST_SCAN && v_s1 && !hit && seg_end
						&& seg2_q) begin
						// move to the wrapped segment
						seg2_q <= 1'b0;
						ia_q   <= '0;
						v_s1   <= 1'b0;
					end else if (state_q == nfba_pkg::ST_CHECK && v_s1 && !bad
						&& seg_end) begin
						ia_q   <= IAW'(lo_q[PW-1:3]);
						v_s1   <= 1'b0;
						used_q <= used_q - nfba_pkg::CNT_W'(n_q) - nfba_pkg::CNT_W'(1);
						live_q <= live_q - nfba_pkg::CNT_W'(1);
					end else begin
						v_s1 <= can_issue;
						if (can_issue) begin
							ia_q <= ia_q + IAW'(1);
						end
					end
				end
				nfba_pkg::ST_ASET: begin
					ia_q    <= IAW'(c1[PW-1:3]);
					start_q <= (fpos_q == PW'(NBLOCKS)) ? '0 : HAW'(fpos_q);
					used_q  <= used_q + nfba_pkg::CNT_W'(n_q) + nfba_pkg::CNT_W'(1);
					live_q  <= live_q + nfba_pkg::CNT_W'(1);
				end
				nfba_pkg::ST_MWR, nfba_pkg::ST_CWR: begin
					if (!ia_last) begin
						ia_q <= ia_q + IAW'(1);
					end
				end
				nfba_pkg::ST_FCHK: begin
					ia_q <= IAW'(h1[PW-1:3]);
					v_s1 <= 1'b0;
					if (!hbit && !nofit && nf == '0) begin
						used_q <= used_q - nfba_pkg::CNT_W'(1);
						live_q <= live_q - nfba_pkg::CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			nfba_pkg::ST_IDLE: begin
				size_q    <= in_size;
				n_q       <= n_in;
				hdr_q     <= HAW'(hdr_in);
				lo_q      <= st_pos;
				hi_q      <= PW'(NBLOCKS);
				last_q    <= AW'(NBLOCKS >> 3);
				run_q     <= '0;
				res_off_q <= (in_cmd == nfba_pkg::CMD_ALLOC && in_size == '0)
					? nfba_pkg::OFF_W'(END_OFF) : '0;
				res_ok_q  <= (in_cmd == nfba_pkg::CMD_ALLOC && in_size == '0)
					|| (in_cmd == nfba_pkg::CMD_FREE && 32'(in_off) == END_OFF);
			end
			nfba_pkg::ST_SCAN: begin
				if (v_s1) begin
					if (hit) begin
						run_q  <= run_n;
						fpos_q <= hit_pos;
					end else if (seg_end && seg2_q) begin
						lo_q   <= '0;
						hi_q   <= hi2;
						last_q <= hi2[PW-1:3];
						run_q  <= '0;
					end else begin
						run_q <= run_n;
					end
				end
			end
			nfba_pkg::ST_ASET: begin
				lo_q      <= c1;
				hi_q      <= fm1;
				last_q    <= fm1[PW-1:3];
				res_ok_q  <= 1'b1;
				res_off_q <= nfba_pkg::OFF_W'({c1, 3'b000});
			end
			nfba_pkg::ST_FCHK: begin
				n_q    <= nf;
				lo_q   <= h1;
				hi_q   <= hn;
				last_q <= hn[PW-1:3];
				if (!hbit && !nofit && nf == '0) begin
					res_ok_q <= 1'b1;
				end
			end
			nfba_pkg::ST_CHECK: begin
				if (v_s1 && !bad && seg_end) begin
					res_ok_q <= 1'b1;
				end
			end
			nfba_pkg::ST_DONE: begin
				if (out_free) begin
					m_ok_q   <= res_ok_q;
					m_off_q  <= res_off_q;
					m_used_q <= used_q;
					m_live_q <= live_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_ok_q;
	assign m_tdata  = {6'd0, m_live_q, m_used_q, m_off_q};

	`NFBA_ASSERT(a_one_item_at_a_time, (s_tvalid && s_tready |=> !s_tready), "second transaction taken while busy")
	`NFBA_ASSERT_ALWAYS(a_no_accept_in_reset, (!arst_n |=> !s_tready), "ready raised during reset")
	`NFBA_ASSERT(a_rmw_in_range, ((state_q == nfba_pkg::ST_MWR || state_q == nfba_pkg::ST_CWR) |-> ({1'b0, last_q} >= ia_q)), "map write beyond run")
	`NFBA_ASSERT(a_result_after_done, (!$past(m_valid_q) && m_valid_q |-> $past(state_q) == nfba_pkg::ST_DONE), "result raised outside completion")

endmodule
